FILE: rtl/ajt_pkg.sv
// Shared types and constants for the active job tracker.
`timescale 1ns / 1ps
package ajt_pkg;

    localparam int TAG_W   = 12;
    localparam int ID_W    = 15;
    localparam int TIME_W  = 32;
    localparam int NONCE_W = 32;
    localparam int ASIC_W  = 3;
    localparam int CORE_W  = 8;
    localparam int ERR_W   = 8;
    localparam int EV_W    = 3;
    localparam int CFG_IDX_W = 2;

    // request types
    localparam logic [1:0] REQ_ACCEPT = 2'd0;
    localparam logic [1:0] REQ_NONCE  = 2'd1;
    localparam logic [1:0] REQ_DONE   = 2'd2;
    localparam logic [1:0] REQ_FLUSH  = 2'd3;

    // result events
    localparam logic [EV_W-1:0] EV_ACCEPTED  = 3'd0;
    localparam logic [EV_W-1:0] EV_FULL      = 3'd1;
    localparam logic [EV_W-1:0] EV_DONE_REL  = 3'd2;
    localparam logic [EV_W-1:0] EV_STALE_REL = 3'd3;
    localparam logic [EV_W-1:0] EV_FLUSH_REL = 3'd4;
    localparam logic [EV_W-1:0] EV_NONCE     = 3'd5;
    localparam logic [EV_W-1:0] EV_NOT_FOUND = 3'd6;
    localparam logic [EV_W-1:0] EV_FLUSH_END = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT = 2'd1;

    localparam logic [ERR_W-1:0] ERR_MAX = 8'd255;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [ID_W-1:0]    job_id;
        logic [TAG_W-1:0]   job_tag;
        logic [TIME_W-1:0]  now_us;
        logic [ASIC_W-1:0]  asic_num;
        logic [CORE_W-1:0]  core_num;
        logic [NONCE_W-1:0] nonce_value;
        logic               nonce_ok;
    } req_t;

    typedef struct packed {
        logic [EV_W-1:0]    event_res;
        logic [TAG_W-1:0]   out_tag;
        logic [ID_W-1:0]    out_id;
        logic [NONCE_W-1:0] out_nonce;
        logic               disable_flag;
        logic [ASIC_W-1:0]  out_asic;
        logic [CORE_W-1:0]  out_core;
        logic               last;
    } res_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    // back-end status seen by the top level
    typedef struct packed {
        logic       clr_done;
        logic       busy;
        logic [5:0] count;
    } status_t;

endpackage

FILE: rtl/ajt_front.sv
// Front end: request queue and core counter index classification.
`timescale 1ns / 1ps
module ajt_front #(
    parameter int ASICS = 6,
    parameter int CORES_PER_ASIC = 256,
    parameter int CNT_AW = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ajt_pkg::req_t       in_req,
    output logic                q_valid,
    input  logic                q_pop,
    output ajt_pkg::req_t       q_req,
    output logic [CNT_AW-1:0]   q_cidx,
    output logic                q_crange
);
    import ajt_pkg::*;

    typedef struct packed {
        req_t              req;
        logic [CNT_AW-1:0] cidx;
        logic              crange;
    } qent_t;

    qent_t       qmem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push;
    qent_t       cls;

    // classify: counter index and range check
    always_comb
    begin
        cls.req    = in_req;
        cls.crange = (int'(in_req.asic_num) < ASICS) && (int'(in_req.core_num) < CORES_PER_ASIC);
        cls.cidx   = CNT_AW'(int'(in_req.asic_num) * CORES_PER_ASIC + int'(in_req.core_num));
    end

    assign in_ready = (fill_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_req    = qmem[rd_ptr_reg].req;
    assign q_cidx   = qmem[rd_ptr_reg].cidx;
    assign q_crange = qmem[rd_ptr_reg].crange;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qmem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

FILE: rtl/ajt_back.sv
// Back end: job ring walk, error counters and result register.
`timescale 1ns / 1ps
module ajt_back #(
    parameter int DEPTH = 32,
    parameter int NCOUNTERS = 1536,
    parameter int CNT_AW = 11
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ajt_pkg::TIME_W-1:0]   stale_limit,
    input  logic [ajt_pkg::ERR_W-1:0]    error_limit,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  ajt_pkg::req_t                q_req,
    input  logic [CNT_AW-1:0]            q_cidx,
    input  logic                         q_crange,
    output logic                         out_valid,
    input  logic                         out_ready,
    output ajt_pkg::res_t                out_res,
    output ajt_pkg::status_t             status
);
    import ajt_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [CNT_AW-1:0] LAST_CTR = CNT_AW'(NCOUNTERS - 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_FRD  = 4'd3;
    localparam logic [3:0] S_FEM  = 4'd4;
    localparam logic [3:0] S_WRD  = 4'd5;
    localparam logic [3:0] S_WCHK = 4'd6;
    localparam logic [3:0] S_MV   = 4'd7;
    localparam logic [3:0] S_NF   = 4'd8;
    localparam logic [3:0] S_NCNT = 4'd9;
    localparam logic [3:0] S_NEM  = 4'd10;
    localparam logic [3:0] S_DEM  = 4'd11;

    // ring slot add with one wrap
    function automatic logic [IDX_W-1:0] wrap(input logic [CNT_W:0] sum);
        logic [CNT_W:0] d;
        d = (CNT_W+1)'(DEPTH);
        if (sum >= d)
        begin
            return IDX_W'(sum - d);
        end
        return IDX_W'(sum);
    endfunction

    function automatic logic [IDX_W-1:0] inc_slot(input logic [IDX_W-1:0] v);
        return (v == LAST_SLOT) ? '0 : v + 1'b1;
    endfunction

    entry_t            emem [DEPTH];
    logic [ERR_W-1:0]  cmem [NCOUNTERS];

    logic [3:0]        state_reg, state_next;
    req_t              req_reg, req_next;
    logic [CNT_AW-1:0] cidx_reg, cidx_next;
    logic              crange_reg, crange_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  start_reg, start_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  walk_reg, walk_next;
    logic [IDX_W-1:0]  s_reg, s_next;
    logic              hit_reg, hit_next;
    logic              dis_reg, dis_next;
    logic [CNT_AW-1:0] clr_reg, clr_next;
    logic              clr_done_reg, clr_done_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg, out_res_next;

    entry_t            rd_data_reg;
    logic [ERR_W-1:0]  crd_reg;

    logic              e_rd, e_wr, c_rd, c_wr;
    logic [IDX_W-1:0]  e_raddr, e_waddr;
    entry_t            e_wdata;
    logic [CNT_AW-1:0] c_addr;
    logic [ERR_W-1:0]  c_wdata, c_new;
    logic              out_free, emit;
    res_t              emit_res;
    logic              stale;

    assign out_free = !out_valid_reg || out_ready;
    assign stale    = (req_reg.now_us - rd_data_reg.stamp) >= stale_limit;
    assign c_new    = req_reg.nonce_ok ? '0 :
                      ((crd_reg == ERR_MAX) ? ERR_MAX : crd_reg + 1'b1);

    // main sequencer
    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        cidx_next     = cidx_reg;
        crange_next   = crange_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        start_next    = start_reg;
        k_next        = k_reg;
        walk_next     = walk_reg;
        s_next        = s_reg;
        hit_next      = hit_reg;
        dis_next      = dis_reg;
        clr_next      = clr_reg;
        clr_done_next = clr_done_reg;
        q_pop   = 1'b0;
        e_rd    = 1'b0;
        e_wr    = 1'b0;
        c_rd    = 1'b0;
        c_wr    = 1'b0;
        e_raddr = head_reg;
        e_waddr = s_reg;
        e_wdata = rd_data_reg;
        c_addr  = cidx_reg;
        c_wdata = c_new;
        emit    = 1'b0;
        emit_res = '0;

        unique case (state_reg)
            S_CLR:
            begin
                c_wr    = 1'b1;
                c_addr  = clr_reg;
                c_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_CTR)
                begin
                    clr_done_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    req_next    = q_req;
                    cidx_next   = q_cidx;
                    crange_next = q_crange;
                    start_next  = head_reg;
                    walk_next   = count_reg;
                    k_next      = '0;
                    hit_next    = 1'b0;
                    case (q_req.req_type)
                        REQ_ACCEPT: state_next = S_ACC;
                        REQ_FLUSH:  state_next = S_FRD;
                        default:    state_next = S_WRD;
                    endcase
                end
            end
            S_ACC:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_res.out_tag = req_reg.job_tag;
                    emit_res.out_id  = req_reg.job_id;
                    emit_res.last    = 1'b1;
                    if (count_reg == FULL_CNT)
                    begin
                        emit_res.event_res = EV_FULL;
                    end
                    else
                    begin
                        emit_res.event_res = EV_ACCEPTED;
                        e_wr    = 1'b1;
                        e_waddr = wrap({1'b0, CNT_W'(head_reg)} + {1'b0, count_reg});
                        e_wdata.tag   = req_reg.job_tag;
                        e_wdata.id    = req_reg.job_id;
                        e_wdata.stamp = req_reg.now_us;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_FRD:
            begin
                if (k_reg == walk_reg)
                begin
                    if (out_free)
                    begin
                        emit = 1'b1;
                        emit_res.event_res = EV_FLUSH_END;
                        emit_res.last      = 1'b1;
                        head_next  = wrap({1'b0, CNT_W'(head_reg)} + {1'b0, walk_reg});
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    e_rd    = 1'b1;
                    e_raddr = wrap({1'b0, CNT_W'(start_reg)} + {1'b0, k_reg});
                    state_next = S_FEM;
                end
            end
            S_FEM:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_res.event_res = EV_FLUSH_REL;
                    emit_res.out_tag   = rd_data_reg.tag;
                    emit_res.out_id    = rd_data_reg.id;
                    k_next     = k_reg + 1'b1;
                    state_next = S_FRD;
                end
            end
            S_WRD:
            begin
                if (k_reg == walk_reg)
                begin
                    state_next = S_NF;
                end
                else
                begin
                    s_next  = wrap({1'b0, CNT_W'(start_reg)} + {1'b0, k_reg});
                    e_rd    = 1'b1;
                    e_raddr = s_next;
                    state_next = S_WCHK;
                end
            end
            S_WCHK:
            begin
                if (rd_data_reg.id == req_reg.job_id)
                begin
                    if (req_reg.req_type == REQ_DONE)
                    begin
                        state_next = S_DEM;
                    end
                    else if (crange_reg)
                    begin
                        c_rd       = 1'b1;
                        state_next = S_NCNT;
                    end
                    else
                    begin
                        dis_next   = 1'b0;
                        state_next = S_NEM;
                    end
                end
                else if (stale)
                begin
                    if (out_free)
                    begin
                        emit = 1'b1;
                        emit_res.event_res = EV_STALE_REL;
                        emit_res.out_tag   = rd_data_reg.tag;
                        emit_res.out_id    = rd_data_reg.id;
                        if (s_reg != head_reg)
                        begin
                            e_rd       = 1'b1;
                            state_next = S_MV;
                        end
                        else
                        begin
                            head_next  = inc_slot(head_reg);
                            count_next = count_reg - 1'b1;
                            k_next     = k_reg + 1'b1;
                            state_next = S_WRD;
                        end
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_WRD;
                end
            end
            S_MV:
            begin
                // oldest entry fills the released slot
                e_wr       = 1'b1;
                head_next  = inc_slot(head_reg);
                count_next = count_reg - 1'b1;
                if (hit_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_WRD;
                end
            end
            S_NF:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_res.event_res = EV_NOT_FOUND;
                    emit_res.out_id    = req_reg.job_id;
                    emit_res.last      = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_NCNT:
            begin
                c_wr       = 1'b1;
                dis_next   = !req_reg.nonce_ok && (c_new >= error_limit);
                state_next = S_NEM;
            end
            S_NEM:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_res.event_res    = EV_NONCE;
                    emit_res.out_tag      = rd_data_reg.tag;
                    emit_res.out_id       = rd_data_reg.id;
                    emit_res.out_nonce    = req_reg.nonce_value;
                    emit_res.disable_flag = dis_reg;
                    emit_res.out_asic     = req_reg.asic_num;
                    emit_res.out_core     = req_reg.core_num;
                    emit_res.last         = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DEM:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_res.event_res = EV_DONE_REL;
                    emit_res.out_tag   = rd_data_reg.tag;
                    emit_res.out_id    = rd_data_reg.id;
                    emit_res.last      = 1'b1;
                    hit_next = 1'b1;
                    if (s_reg != head_reg)
                    begin
                        e_rd       = 1'b1;
                        state_next = S_MV;
                    end
                    else
                    begin
                        head_next  = inc_slot(head_reg);
                        count_next = count_reg - 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_res_next   = emit_res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // entry ring memory
    always_ff @(posedge clk)
    begin
        if (e_wr)
        begin
            emem[e_waddr] <= e_wdata;
        end
        if (e_rd)
        begin
            rd_data_reg <= emem[e_raddr];
        end
    end

    // error counter memory
    always_ff @(posedge clk)
    begin
        if (c_wr)
        begin
            cmem[c_addr] <= c_wdata;
        end
        if (c_rd)
        begin
            crd_reg <= cmem[c_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        cidx_reg    <= cidx_next;
        crange_reg  <= crange_next;
        start_reg   <= start_next;
        walk_reg    <= walk_next;
        s_reg       <= s_next;
        dis_reg     <= dis_next;
        out_res_reg <= out_res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            head_reg      <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            hit_reg       <= 1'b0;
            clr_reg       <= '0;
            clr_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            hit_reg       <= hit_next;
            clr_reg       <= clr_next;
            clr_done_reg  <= clr_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_res         = out_res_reg;
    assign status.clr_done = clr_done_reg;
    assign status.busy     = (state_reg != S_IDLE);
    assign status.count    = 6'(count_reg);

endmodule

FILE: rtl/active_job_tracker.sv
// Top level of the active job tracker: config registers, front, back.
//
// Usage: requests enter on in_valid/in_ready (accept, nonce, done, flush).
// Each request yields one or more results on out_valid/out_ready; the final
// result of a request has last set. Configuration (stale_limit at index 0,
// error_limit at index 1) is written on cfg_valid/cfg_ready. The user must
// write it only while idle; the block itself does not enforce this.
// Operation: an accept checks for room and writes one entry. A nonce or done
// request walks the ring from the oldest entry up to the matching one,
// releasing stale entries as it passes them; a released entry is refilled
// from the oldest slot. A flush releases every entry in order, then reports
// its end. The back end finishes one request before it pops the next.
// Reset: the ring empties and the per-core error counters are cleared by a
// sweep over the ASICS*CORES_PER_ASIC counters (1536 by default), in which no
// result is produced; up to two requests queue meanwhile.
// Receiver stall: a finished result waits in the output register and the
// walk pauses; the two-entry input queue keeps accepting requests until full.
`timescale 1ns / 1ps
module active_job_tracker #(
    parameter int DEPTH = 32,
    parameter int ASICS = 6,
    parameter int CORES_PER_ASIC = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ajt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        req_type,
    input  logic [ajt_pkg::ID_W-1:0]          job_id,
    input  logic [ajt_pkg::TAG_W-1:0]         job_tag,
    input  logic [ajt_pkg::TIME_W-1:0]        now_us,
    input  logic [ajt_pkg::ASIC_W-1:0]        asic_num,
    input  logic [ajt_pkg::CORE_W-1:0]        core_num,
    input  logic [ajt_pkg::NONCE_W-1:0]       nonce_value,
    input  logic                              nonce_ok,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ajt_pkg::EV_W-1:0]          event_res,
    output logic [ajt_pkg::TAG_W-1:0]         out_tag,
    output logic [ajt_pkg::ID_W-1:0]          out_id,
    output logic [ajt_pkg::NONCE_W-1:0]       out_nonce,
    output logic                              disable_flag,
    output logic [ajt_pkg::ASIC_W-1:0]        out_asic,
    output logic [ajt_pkg::CORE_W-1:0]        out_core,
    output logic                              last
);
    import ajt_pkg::*;

    localparam int NCOUNTERS = ASICS * CORES_PER_ASIC;
    localparam int CNT_AW = (NCOUNTERS > 1) ? $clog2(NCOUNTERS) : 1;

    logic [TIME_W-1:0] stale_limit_reg;
    logic [ERR_W-1:0]  error_limit_reg;
    req_t              in_req;
    logic              q_valid, q_pop, q_crange;
    req_t              q_req;
    logic [CNT_AW-1:0] q_cidx;
    res_t              out_res;
    status_t           status;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_limit_reg <= 32'd60000000;
            error_limit_reg <= 8'd10;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_STALE_LIMIT: stale_limit_reg <= cfg_data;
                REG_ERROR_LIMIT: error_limit_reg <= cfg_data[ERR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        in_req.req_type    = req_type;
        in_req.job_id      = job_id;
        in_req.job_tag     = job_tag;
        in_req.now_us      = now_us;
        in_req.asic_num    = asic_num;
        in_req.core_num    = core_num;
        in_req.nonce_value = nonce_value;
        in_req.nonce_ok    = nonce_ok;
    end

    ajt_front #(
        .ASICS(ASICS),
        .CORES_PER_ASIC(CORES_PER_ASIC),
        .CNT_AW(CNT_AW)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_req(in_req),
        .q_valid(q_valid),
        .q_pop(q_pop),
        .q_req(q_req),
        .q_cidx(q_cidx),
        .q_crange(q_crange)
    );

    ajt_back #(
        .DEPTH(DEPTH),
        .NCOUNTERS(NCOUNTERS),
        .CNT_AW(CNT_AW)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .stale_limit(stale_limit_reg),
        .error_limit(error_limit_reg),
        .q_valid(q_valid),
        .q_pop(q_pop),
        .q_req(q_req),
        .q_cidx(q_cidx),
        .q_crange(q_crange),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_res(out_res),
        .status(status)
    );

    assign event_res    = out_res.event_res;
    assign out_tag      = out_res.out_tag;
    assign out_id       = out_res.out_id;
    assign out_nonce    = out_res.out_nonce;
    assign disable_flag = out_res.disable_flag;
    assign out_asic     = out_res.out_asic;
    assign out_core     = out_res.out_core;
    assign last         = out_res.last;

    // ring occupancy never exceeds its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(status.count) <= DEPTH)
        else $error("ring occupancy above depth");

    // no result while the counter sweep runs
    a_no_out_clr: assert property (@(posedge clk) disable iff (!rst_n)
        !status.clr_done |-> !out_valid)
        else $error("result during counter clear");

    // disable only flagged on nonce events
    a_dis_nonce: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && disable_flag |-> event_res == EV_NONCE)
        else $error("disable on non-nonce event");

    // an idle back end with a result pending has marked it last
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status.busy && !$past(out_valid && out_ready) |-> last)
        else $error("idle with non-final result");

endmodule

FILE: dv/active_job_tracker_test.sv
// Self-checking testbench for the active job tracker: random and directed requests.
`timescale 1ns / 1ps
module active_job_tracker_test;
    import ajt_pkg::*;

    localparam int DEPTH     = 32;
    localparam int ASICS     = 6;
    localparam int CORES     = 256;
    localparam int SETTLE    = 2 * DEPTH + 20;
    localparam int MAX_CYCLE = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    req_t cur_req = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    res_t seen;

    // tracker state mirrored by the predictor
    logic [TAG_W-1:0]  slot_tag [DEPTH];
    logic [ID_W-1:0]   slot_id [DEPTH];
    logic [TIME_W-1:0] slot_time [DEPTH];
    int unsigned       head_slot;
    int unsigned       live_cnt;
    logic [ERR_W-1:0]  core_errs [ASICS*CORES];
    logic [31:0]       stale_lim;
    logic [7:0]        err_lim;
    logic [31:0]       clock_us;

    req_t pending_reqs [$];
    res_t expected_events [$];
    int errors = 0;
    int cycles = 0;
    int burst_left = 0;
    int gap_left = 0;

    active_job_tracker i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(cur_req.req_type), .job_id(cur_req.job_id),
        .job_tag(cur_req.job_tag), .now_us(cur_req.now_us),
        .asic_num(cur_req.asic_num), .core_num(cur_req.core_num),
        .nonce_value(cur_req.nonce_value), .nonce_ok(cur_req.nonce_ok),
        .out_valid(out_valid), .out_ready(out_ready),
        .event_res(seen.event_res), .out_tag(seen.out_tag), .out_id(seen.out_id),
        .out_nonce(seen.out_nonce), .disable_flag(seen.disable_flag),
        .out_asic(seen.out_asic), .out_core(seen.out_core), .last(seen.last)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic res_t mk_event(input logic [EV_W-1:0] ev, input logic [TAG_W-1:0] tag,
                                      input logic [ID_W-1:0] id);
        res_t r;
        r = '0;
        r.event_res = ev;
        r.out_tag = tag;
        r.out_id = id;
        return r;
    endfunction

    // free a slot: oldest entry moves in, oldest position dropped
    task free_slot(input int unsigned s);
        if (s != head_slot)
        begin
            slot_tag[s] = slot_tag[head_slot];
            slot_id[s] = slot_id[head_slot];
            slot_time[s] = slot_time[head_slot];
        end
        head_slot = (head_slot + 1) % DEPTH;
        live_cnt--;
    endtask

    // compute the events one request causes and queue them
    task predict_events(input req_t r);
        int unsigned start, cnt, s, k, c;
        bit found;
        res_t ev;
        found = 0;
        s = 0;
        case (r.req_type)
            REQ_ACCEPT:
            begin
                if (live_cnt >= DEPTH)
                    expected_events.push_back(mk_event(EV_FULL, r.job_tag, r.job_id));
                else
                begin
                    s = (head_slot + live_cnt) % DEPTH;
                    slot_tag[s] = r.job_tag;
                    slot_id[s] = r.job_id;
                    slot_time[s] = r.now_us;
                    live_cnt++;
                    expected_events.push_back(mk_event(EV_ACCEPTED, r.job_tag, r.job_id));
                end
            end
            REQ_FLUSH:
            begin
                for (k = 0; k < live_cnt; k++)
                begin
                    s = (head_slot + k) % DEPTH;
                    expected_events.push_back(mk_event(EV_FLUSH_REL, slot_tag[s], slot_id[s]));
                end
                head_slot = (head_slot + live_cnt) % DEPTH;
                live_cnt = 0;
                expected_events.push_back(mk_event(EV_FLUSH_END, '0, '0));
            end
            default:
            begin
                start = head_slot;
                cnt = live_cnt;
                for (k = 0; k < cnt; k++)
                begin
                    s = (start + k) % DEPTH;
                    if (slot_id[s] == r.job_id)
                    begin
                        found = 1;
                        break;
                    end
                    if (32'(r.now_us - slot_time[s]) >= stale_lim)
                    begin
                        expected_events.push_back(mk_event(EV_STALE_REL, slot_tag[s], slot_id[s]));
                        free_slot(s);
                    end
                end
                if (!found)
                    expected_events.push_back(mk_event(EV_NOT_FOUND, '0, r.job_id));
                else if (r.req_type == REQ_NONCE)
                begin
                    ev = mk_event(EV_NONCE, slot_tag[s], slot_id[s]);
                    ev.out_nonce = r.nonce_value;
                    ev.out_asic = r.asic_num;
                    ev.out_core = r.core_num;
                    if (r.asic_num < ASICS)
                    begin
                        c = r.asic_num * CORES + r.core_num;
                        if (r.nonce_ok)
                            core_errs[c] = '0;
                        else
                        begin
                            if (core_errs[c] < ERR_MAX)
                                core_errs[c]++;
                            if (core_errs[c] >= err_lim)
                                ev.disable_flag = 1'b1;
                        end
                    end
                    expected_events.push_back(ev);
                end
                else
                begin
                    expected_events.push_back(mk_event(EV_DONE_REL, slot_tag[s], slot_id[s]));
                    free_slot(s);
                end
            end
        endcase
        expected_events[expected_events.size()-1].last = 1'b1;
    endtask

    task send(input logic [1:0] kind, input logic [ID_W-1:0] id, input logic [TAG_W-1:0] tag,
              input logic [31:0] now, input logic [2:0] asic, input logic [7:0] core,
              input logic ok);
        req_t r;
        r.req_type = kind;
        r.job_id = id;
        r.job_tag = tag;
        r.now_us = now;
        r.asic_num = asic;
        r.core_num = core;
        r.nonce_value = $urandom;
        r.nonce_ok = ok;
        predict_events(r);
        pending_reqs.push_back(r);
    endtask

    // id of a random live entry, or a random id when empty
    function automatic logic [ID_W-1:0] live_id();
        if (live_cnt == 0)
            return ID_W'($urandom);
        return slot_id[(head_slot + $urandom_range(0, live_cnt - 1)) % DEPTH];
    endfunction

    // one random request, mostly well-formed
    task rand_request(input bit hot);
        int unsigned pick;
        logic [2:0] asic;
        logic [7:0] core;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            clock_us = clock_us + stale_lim - $urandom_range(0, 2);
        else if (pick < 11)
            clock_us = $urandom;
        else
            clock_us = clock_us + $urandom_range(0, 2000);
        asic = $urandom_range(0, 7);
        core = $urandom;
        if (hot && $urandom_range(0, 9) < 6)
        begin
            case ($urandom_range(0, 2))
                0: begin asic = 0; core = 0; end
                1: begin asic = 5; core = 8'hff; end
                default: begin asic = 6; core = 1; end
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 40 || live_cnt == 0 && pick < 70)
            send(REQ_ACCEPT, $urandom, $urandom, clock_us, asic, core, $urandom);
        else if (pick < 70)
            send(REQ_NONCE, live_id(), $urandom, clock_us, asic, core,
                 $urandom_range(0, 3) == 0);
        else if (pick < 92)
            send(REQ_DONE, live_id(), $urandom, clock_us, asic, core, $urandom);
        else if (pick < 95)
            send(REQ_FLUSH, $urandom, $urandom, clock_us, asic, core, $urandom);
        else
            send(($urandom_range(0, 1) != 0) ? REQ_NONCE : REQ_DONE, $urandom, $urandom,
                 clock_us, asic, core, $urandom);
    endtask

    task wait_idle();
        do @(posedge clk);
        while (pending_reqs.size() != 0 || expected_events.size() != 0 || in_valid);
        repeat (SETTLE) @(posedge clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_STALE_LIMIT)
            stale_lim = val;
        else
            err_lim = val[7:0];
    endtask

    task set_limits(input logic [31:0] stale, input logic [7:0] errl);
        wait_idle();
        write_reg(REG_STALE_LIMIT, stale);
        write_reg(REG_ERROR_LIMIT, errl);
    endtask

    // request driver: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                pending_reqs.delete(0);
            if (in_valid && !in_ready)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                cur_req <= pending_reqs[0];
                in_valid <= 1'b1;
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 12);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor and checker; receiver stalls in some windows only
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= (cycles[9:8] == 2'd0) ? 1'b1 :
                         (cycles[9:8] == 2'd1) ? ($urandom_range(0, 3) != 0) :
                         ($urandom_range(0, 1) != 0);
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("unexpected result event %0d id %0h", seen.event_res, seen.out_id);
                    errors++;
                end
                else
                begin
                    if (seen.event_res !== expected_events[0].event_res)
                        report("event_res", seen.event_res, expected_events[0].event_res);
                    if (seen.out_tag !== expected_events[0].out_tag)
                        report("out_tag", seen.out_tag, expected_events[0].out_tag);
                    if (seen.out_id !== expected_events[0].out_id)
                        report("out_id", seen.out_id, expected_events[0].out_id);
                    if (seen.out_nonce !== expected_events[0].out_nonce)
                        report("out_nonce", seen.out_nonce, expected_events[0].out_nonce);
                    if (seen.disable_flag !== expected_events[0].disable_flag)
                        report("disable_flag", seen.disable_flag,
                               expected_events[0].disable_flag);
                    if (seen.out_asic !== expected_events[0].out_asic)
                        report("out_asic", seen.out_asic, expected_events[0].out_asic);
                    if (seen.out_core !== expected_events[0].out_core)
                        report("out_core", seen.out_core, expected_events[0].out_core);
                    if (seen.last !== expected_events[0].last)
                        report("last", seen.last, expected_events[0].last);
                    expected_events.delete(0);
                end
            end
        end
    end

    // stimulus sequence
    initial
    begin
        int i;
        head_slot = 0;
        live_cnt = 0;
        stale_lim = 32'd60000000;
        err_lim = 8'd10;
        clock_us = 0;
        foreach (core_errs[j])
            core_errs[j] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, each request type, out-of-range core, not found
        send(REQ_ACCEPT, '0, '0, '0, 0, 0, 0);
        send(REQ_ACCEPT, '1, '1, '1, 7, 8'hff, 1);
        send(REQ_NONCE, '1, '0, 32'd5, 7, 8'hff, 0);
        send(REQ_NONCE, '0, '1, 32'd6, 5, 8'hff, 0);
        send(REQ_NONCE, '0, '0, 32'd7, 5, 8'hff, 1);
        send(REQ_NONCE, 15'h1234, '0, 32'd8, 0, 0, 0);
        send(REQ_DONE, 15'h4321, '0, 32'd60000010, 0, 0, 0);
        send(REQ_ACCEPT, 15'h2aaa, 12'h555, 32'd60000010, 0, 0, 0);
        send(REQ_DONE, 15'h2aaa, '0, 32'd60000011, 0, 0, 0);
        send(REQ_ACCEPT, 15'h5555, 12'haaa, 32'hfffffff0, 0, 0, 0);
        send(REQ_ACCEPT, 15'h0f0f, 12'h0f0, 32'h00000010, 0, 0, 0);
        send(REQ_FLUSH, '0, '0, '0, 0, 0, 0);
        send(REQ_FLUSH, '0, '0, '0, 0, 0, 0);

        // smallest limits: every passed entry with an older stamp is stale, every bad nonce on an in-range core flags
        set_limits(32'd1, 8'd1);
        for (i = 0; i < 45; i++)
            rand_request(1);

        // largest limits, fill the ring past full
        set_limits(32'hffffffff, 8'd255);
        for (i = 0; i < 36; i++)
        begin
            clock_us = clock_us + 1;
            send(REQ_ACCEPT, $urandom, $urandom, clock_us, 0, 0, 0);
        end
        send(REQ_DONE, live_id(), '0, clock_us - 32'd1 - slot_time[head_slot], 0, 0, 0);
        for (i = 0; i < 25; i++)
            rand_request(0);

        set_limits(32'd1000, 8'd3);
        for (i = 0; i < 45; i++)
            rand_request(1);

        // drive one core's error counter past its limit, then clear it
        set_limits(32'hffffffff, 8'd64);
        send(REQ_FLUSH, '0, '0, clock_us, 0, 0, 0);
        send(REQ_ACCEPT, 15'h0333, 12'h333, clock_us, 0, 0, 0);
        for (i = 0; i < 70; i++)
            send(REQ_NONCE, 15'h0333, '0, clock_us, 2, 3, 0);
        send(REQ_NONCE, 15'h0333, '0, clock_us, 2, 3, 1);
        send(REQ_NONCE, 15'h0333, '0, clock_us, 2, 3, 0);

        set_limits(32'd60000000, 8'd10);
        for (i = 0; i < 40; i++)
            rand_request(1);

        wait_idle();
        if (errors == 0 && expected_events.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

FILE: files.f
rtl/ajt_pkg.sv
rtl/ajt_front.sv
rtl/ajt_back.sv
rtl/active_job_tracker.sv
dv/active_job_tracker_test.sv
